// ===== src/ptc_pkg.sv =====
// Types and constants for the pressure/temperature compensation block.
package ptc_pkg;

    localparam int ADC_BITS_DEF = 24;
    localparam int RAW_W        = 24;
    localparam int CAL_W        = 16;
    localparam int P_W          = 20;
    localparam int T_W          = 16;
    localparam int APB_AW       = 5;
    localparam int APB_DW       = 32;

    localparam int DT_W    = 25;
    localparam int MUL_W   = 42;
    localparam int Q_W     = 18;
    localparam int SENS1_W = 34;
    localparam int OFF1_W  = 35;
    localparam int CORR_W  = 38;
    localparam int PS_W    = 40;
    localparam int PROD_W  = 65;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_VLOW = -1500;

    localparam logic signed [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
    localparam logic signed [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } cal_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } req_t;

    typedef struct packed {
        logic signed [P_W-1:0] pressure_decimbar;
        logic signed [T_W-1:0] temp_centideg;
    } rsp_t;

endpackage

// ===== src/pressure_temp_compensation.sv =====
// Ten-stage pipeline: second-order compensated pressure and temperature.
// Throughput: one request per cycle; a stage holds only while it and every later stage
// are full and rsp_stall is high.
// Pace is set by the split 24x40 pressure multiply (partial products, then the recombine add).
// Reset: rst_n async low clears pipeline valids and all six calibration words to zero.
module pressure_temp_compensation #(
    parameter int ADC_BITS = ptc_pkg::ADC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  ptc_pkg::req_t               req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output ptc_pkg::rsp_t               rsp_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptc_pkg::APB_AW-1:0]  paddr,
    input  logic [ptc_pkg::APB_DW-1:0]  pwdata,
    output logic [ptc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import ptc_pkg::*;

    localparam int NSTG  = 10;
    localparam int PPL_W = ADC_BITS + 20;
    localparam int PPH_W = ADC_BITS + 21;
    localparam logic [RAW_W-1:0] AMASK = RAW_W'((33'd1 << ADC_BITS) - 33'd1);
    localparam logic signed [DT_W-1:0] C5_ZERO = '0;
    localparam logic signed [Q_W:0]   E_OFS  = 19'(TEMP_REF - TEMP_VLOW);
    localparam logic signed [Q_W-1:0] Q_VLOW = 18'(TEMP_VLOW - TEMP_REF);
    localparam logic signed [T_W+3:0] T_REF  = 20'(TEMP_REF);

    // calibration registers
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_C1:  c1_reg <= pwdata[CAL_W-1:0];
                REG_C2:  c2_reg <= pwdata[CAL_W-1:0];
                REG_C3:  c3_reg <= pwdata[CAL_W-1:0];
                REG_C4:  c4_reg <= pwdata[CAL_W-1:0];
                REG_C5:  c5_reg <= pwdata[CAL_W-1:0];
                REG_C6:  c6_reg <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_C1:  prdata = {{(APB_DW-CAL_W){1'b0}}, c1_reg};
            REG_C2:  prdata = {{(APB_DW-CAL_W){1'b0}}, c2_reg};
            REG_C3:  prdata = {{(APB_DW-CAL_W){1'b0}}, c3_reg};
            REG_C4:  prdata = {{(APB_DW-CAL_W){1'b0}}, c4_reg};
            REG_C5:  prdata = {{(APB_DW-CAL_W){1'b0}}, c5_reg};
            REG_C6:  prdata = {{(APB_DW-CAL_W){1'b0}}, c6_reg};
            default: prdata = '0;
        endcase
    end

    // pipeline flow control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || !rsp_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign req_stall = !en[0];
    assign rsp_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= req_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: dT
    logic [RAW_W-1:0]       d2m;
    logic signed [DT_W-1:0] s1_dt_reg;
    logic [ADC_BITS-1:0]    s1_d1_reg;

    assign d2m = req_data.raw_temperature & AMASK;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_dt_reg <= $signed({1'b0, d2m}) - $signed({1'b0, c5_reg, 8'h00}) + C5_ZERO;
            s1_d1_reg <= req_data.raw_pressure[ADC_BITS-1:0];
        end
    end

    // stage 2: products with dT
    logic signed [MUL_W-1:0]  p6, p3, p4;
    logic signed [2*DT_W-1:0] sq;
    logic signed [MUL_W-1:0]  s2_p6_reg, s2_p3_reg, s2_p4_reg;
    logic [47:0]              s2_sq_reg;
    logic [ADC_BITS-1:0]      s2_d1_reg;

    always_comb
    begin
        p6 = $signed({1'b0, c6_reg}) * s1_dt_reg;
        p3 = $signed({1'b0, c3_reg}) * s1_dt_reg;
        p4 = $signed({1'b0, c4_reg}) * s1_dt_reg;
        sq = s1_dt_reg * s1_dt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_p6_reg <= p6;
            s2_p3_reg <= p3;
            s2_p4_reg <= p4;
            s2_sq_reg <= sq[47:0];
            s2_d1_reg <= s1_d1_reg;
        end
    end

    // stage 3: first-order TEMP offset, OFF, SENS; second-order Ti candidates
    logic [MUL_W-1:0]           t6, t3, t4;
    logic [49:0]                sq3;
    logic signed [SENS1_W-1:0]  sens1;
    logic signed [OFF1_W-1:0]   off1;
    logic signed [Q_W-1:0]      s3_q_reg;
    logic signed [SENS1_W-1:0]  s3_sens1_reg;
    logic signed [OFF1_W-1:0]   s3_off1_reg;
    logic [11:0]                s3_tige_reg;
    logic [16:0]                s3_tilt_reg;
    logic [ADC_BITS-1:0]        s3_d1_reg;

    always_comb
    begin
        t6    = s2_p6_reg + {{(MUL_W-23){1'b0}}, {23{s2_p6_reg[MUL_W-1]}}};
        t3    = s2_p3_reg + {{(MUL_W-8){1'b0}}, {8{s2_p3_reg[MUL_W-1]}}};
        t4    = s2_p4_reg + {{(MUL_W-7){1'b0}}, {7{s2_p4_reg[MUL_W-1]}}};
        sens1 = $signed({3'b000, c1_reg, 15'h0000}) + $signed(t3[41:8]);
        off1  = $signed({3'b000, c2_reg, 16'h0000}) + $signed(t4[41:7]);
        sq3   = {2'b00, s2_sq_reg} + {1'b0, s2_sq_reg, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_q_reg     <= $signed(t6[40:23]);
            s3_sens1_reg <= sens1;
            s3_off1_reg  <= off1;
            s3_tige_reg  <= s2_sq_reg[47:36];
            s3_tilt_reg  <= sq3[49:33];
            s3_d1_reg    <= s2_d1_reg;
        end
    end

    // stage 4: squares of TEMP-2000 and TEMP+1500, region flags
    logic signed [2*Q_W-1:0]   dd_full;
    logic signed [Q_W:0]       e4;
    logic signed [2*Q_W+1:0]   ee_full;
    logic [33:0]               s4_dd_reg;
    logic [34:0]               s4_ee_reg;
    logic                      s4_ge_reg, s4_vlow_reg;
    logic signed [Q_W-1:0]     s4_q_reg;
    logic signed [SENS1_W-1:0] s4_sens1_reg;
    logic signed [OFF1_W-1:0]  s4_off1_reg;
    logic [11:0]               s4_tige_reg;
    logic [16:0]               s4_tilt_reg;
    logic [ADC_BITS-1:0]       s4_d1_reg;

    always_comb
    begin
        dd_full = s3_q_reg * s3_q_reg;
        e4      = $signed({s3_q_reg[Q_W-1], s3_q_reg}) + E_OFS;
        ee_full = e4 * e4;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_dd_reg    <= dd_full[33:0];
            s4_ee_reg    <= ee_full[34:0];
            s4_ge_reg    <= !s3_q_reg[Q_W-1];
            s4_vlow_reg  <= s3_q_reg < Q_VLOW;
            s4_q_reg     <= s3_q_reg;
            s4_sens1_reg <= s3_sens1_reg;
            s4_off1_reg  <= s3_off1_reg;
            s4_tige_reg  <= s3_tige_reg;
            s4_tilt_reg  <= s3_tilt_reg;
            s4_d1_reg    <= s3_d1_reg;
        end
    end

    // stage 5: OFFi, SENSi, final temperature
    logic [CORR_W-1:0]         dd38, ee38, offi, sensi;
    logic [16:0]               ti;
    logic signed [T_W+3:0]     tt;
    logic signed [T_W-1:0]     tsat;
    logic [CORR_W-1:0]         s5_offi_reg, s5_sensi_reg;
    logic signed [SENS1_W-1:0] s5_sens1_reg;
    logic signed [OFF1_W-1:0]  s5_off1_reg;
    logic signed [T_W-1:0]     s5_t_reg;
    logic [ADC_BITS-1:0]       s5_d1_reg;

    always_comb
    begin
        dd38 = {4'h0, s4_dd_reg};
        ee38 = {3'b000, s4_ee_reg};
        if (s4_ge_reg)
        begin
            offi  = dd38 >> 4;
            sensi = '0;
            ti    = {5'b00000, s4_tige_reg};
        end
        else
        begin
            offi  = ((dd38 << 1) + dd38) >> 1;
            sensi = ((dd38 << 2) + dd38) >> 3;
            ti    = s4_tilt_reg;
            if (s4_vlow_reg)
            begin
                offi  = offi + ((ee38 << 3) - ee38);
                sensi = sensi + (ee38 << 2);
            end
        end
        tt = $signed({{2{s4_q_reg[Q_W-1]}}, s4_q_reg}) + T_REF - $signed({3'b000, ti});
        if (tt > $signed({{4{T_MAX[T_W-1]}}, T_MAX}))
        begin
            tsat = T_MAX;
        end
        else if (tt < $signed({{4{T_MIN[T_W-1]}}, T_MIN}))
        begin
            tsat = T_MIN;
        end
        else
        begin
            tsat = tt[T_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_offi_reg  <= offi;
            s5_sensi_reg <= sensi;
            s5_sens1_reg <= s4_sens1_reg;
            s5_off1_reg  <= s4_off1_reg;
            s5_t_reg     <= tsat;
            s5_d1_reg    <= s4_d1_reg;
        end
    end

    // stage 6: corrected OFF and SENS
    logic signed [PS_W-1:0] s6_off_reg, s6_sens_reg;
    logic signed [T_W-1:0]  s6_t_reg;
    logic [ADC_BITS-1:0]    s6_d1_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_off_reg  <= $signed({{(PS_W-OFF1_W){s5_off1_reg[OFF1_W-1]}}, s5_off1_reg})
                           - $signed({2'b00, s5_offi_reg});
            s6_sens_reg <= $signed({{(PS_W-SENS1_W){s5_sens1_reg[SENS1_W-1]}}, s5_sens1_reg})
                           - $signed({2'b00, s5_sensi_reg});
            s6_t_reg    <= s5_t_reg;
            s6_d1_reg   <= s5_d1_reg;
        end
    end

    // stage 7: D1 * SENS partial products
    logic [PPL_W-1:0]        ppl;
    logic signed [PPH_W-1:0] pph;
    logic [PPL_W-1:0]        s7_ppl_reg;
    logic signed [PPH_W-1:0] s7_pph_reg;
    logic signed [PS_W-1:0]  s7_off_reg;
    logic signed [T_W-1:0]   s7_t_reg;

    always_comb
    begin
        ppl = s6_d1_reg * s6_sens_reg[19:0];
        pph = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[PS_W-1:20]);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_ppl_reg <= ppl;
            s7_pph_reg <= pph;
            s7_off_reg <= s6_off_reg;
            s7_t_reg   <= s6_t_reg;
        end
    end

    // stage 8: recombine
    logic signed [PROD_W-1:0] s8_prod_reg;
    logic signed [PS_W-1:0]   s8_off_reg;
    logic signed [T_W-1:0]    s8_t_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_prod_reg <= $signed(PROD_W'(s7_pph_reg) <<< 20) + $signed(PROD_W'(s7_ppl_reg));
            s8_off_reg  <= s7_off_reg;
            s8_t_reg    <= s7_t_reg;
        end
    end

    // stage 9: D1*SENS/2^21 - OFF
    logic [PROD_W-1:0]     t9;
    logic [43:0]           a9;
    logic signed [44:0]    s9_q2_reg;
    logic signed [T_W-1:0] s9_t_reg;

    always_comb
    begin
        t9 = s8_prod_reg + {{(PROD_W-21){1'b0}}, {21{s8_prod_reg[PROD_W-1]}}};
        a9 = t9[PROD_W-1:21];
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s9_q2_reg <= $signed({a9[43], a9}) - $signed({{5{s8_off_reg[PS_W-1]}}, s8_off_reg});
            s9_t_reg  <= s8_t_reg;
        end
    end

    // stage 10: /2^13, saturate, result register
    logic [44:0]           t10;
    logic signed [31:0]    p32;
    logic signed [P_W-1:0] psat;
    rsp_t                  rsp_reg;

    always_comb
    begin
        t10 = s9_q2_reg + {32'h0, {13{s9_q2_reg[44]}}};
        p32 = $signed(t10[44:13]);
        if (p32 > $signed({{(32-P_W){P_MAX[P_W-1]}}, P_MAX}))
        begin
            psat = P_MAX;
        end
        else if (p32 < $signed({{(32-P_W){P_MIN[P_W-1]}}, P_MIN}))
        begin
            psat = P_MIN;
        end
        else
        begin
            psat = p32[P_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            rsp_reg.pressure_decimbar <= psat;
            rsp_reg.temp_centideg     <= s9_t_reg;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

// ===== tb/pressure_temp_compensation_tb.sv =====
// Testbench for pressure_temp_compensation: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module pressure_temp_compensation_tb;
    import ptc_pkg::*;

    localparam int NUM_CAL         = 6;
    localparam int UNMAPPED_IDX    = 6;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int NUM_PHASES      = 5;
    localparam longint RAW_MAX     = (64'sd1 << RAW_W) - 1;
    localparam longint ADC_MASK    = (64'sd1 << ADC_BITS_DEF) - 1;
    localparam logic [CAL_W-1:0] CAL_MAX = '1;
    // dT offsets around the reference reading: region edges and the cold region
    localparam longint DT_PROBES[9] = '{0, -321, -322, 321, 4000, -1122000, -1123000,
                                        -2000000, 3000000};

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    class ptc_scoreboard;
        logic [CAL_W-1:0] cal[NUM_CAL];
        rsp_t expected_readings[$];
        int fails;

        function new();
            foreach (cal[i]) cal[i] = '0;
            fails = 0;
        endfunction

        function void set_cal(int idx, logic [CAL_W-1:0] value);
            if (idx < NUM_CAL) cal[idx] = value;
        endfunction

        function rsp_t compensate(req_t r);
            longint d1, d2, c1, c2, c3, c4, c5, c6;
            longint dt, temp, sens, off, ti, offi, sensi, dd, ee, p, t;
            rsp_t y;
            d1 = longint'(r.raw_pressure) & ADC_MASK;
            d2 = longint'(r.raw_temperature) & ADC_MASK;
            c1 = cal[REG_C1];
            c2 = cal[REG_C2];
            c3 = cal[REG_C3];
            c4 = cal[REG_C4];
            c5 = cal[REG_C5];
            c6 = cal[REG_C6];

            dt   = d2 - c5 * 256;
            temp = TEMP_REF + (c6 * dt) / 8388608;
            sens = c1 * 32768 + (c3 * dt) / 256;
            off  = c2 * 65536 + (c4 * dt) / 128;

            dd = (temp - TEMP_REF) * (temp - TEMP_REF);
            if (temp >= TEMP_REF) begin
                ti    = (2 * dt * dt) / 64'sd137438953472;
                offi  = dd / 16;
                sensi = 0;
            end
            else begin
                ti    = (3 * dt * dt) / 64'sd8589934592;
                offi  = (3 * dd) / 2;
                sensi = (5 * dd) / 8;
                if (temp < TEMP_VLOW) begin
                    ee    = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
                    offi  += 7 * ee;
                    sensi += 4 * ee;
                end
            end

            p = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
            t = temp - ti;
            if (p > longint'(P_MAX))
                p = P_MAX;
            else if (p < longint'(P_MIN))
                p = P_MIN;
            if (t > longint'(T_MAX))
                t = T_MAX;
            else if (t < longint'(T_MIN))
                t = T_MIN;

            y.pressure_decimbar = p[P_W-1:0];
            y.temp_centideg     = t[T_W-1:0];
            return y;
        endfunction

        function void note_request(req_t r);
            expected_readings.push_back(compensate(r));
        endfunction

        function void check_reading(rsp_t got);
            rsp_t want;
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: pressure_decimbar %0d temp_centideg %0d",
                       got.pressure_decimbar, got.temp_centideg);
                fails++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.pressure_decimbar !== want.pressure_decimbar) begin
                $error("pressure_decimbar: expected %0d, actual %0d",
                       want.pressure_decimbar, got.pressure_decimbar);
                fails++;
            end
            if (got.temp_centideg !== want.temp_centideg) begin
                $error("temp_centideg: expected %0d, actual %0d",
                       want.temp_centideg, got.temp_centideg);
                fails++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    ptc_scoreboard board = new();
    int burst_left = 0;
    bit hold_off_pending = 1'b0;
    int idle_cycles = 0;

    pressure_temp_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            board.note_request(req_data);
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_reading(rsp_data);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side stall pattern
    initial
    begin
        stall_mode_t mode;
        int span;
        int tick;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_pending) begin
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (tick = 0; tick < span && !hold_off_pending; tick++) begin
                case (mode)
                    STALL_NONE:     rsp_stall <= 1'b0;
                    STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 70);
                    STALL_PERIODIC: rsp_stall <= (tick % 5 < 2);
                    default:        rsp_stall <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic cal_write(input int idx, input logic [CAL_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_cal(idx, value);
    endtask

    task automatic load_cal(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                            input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                            input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
        cal_write(REG_C1, c1);
        cal_write(REG_C2, c2);
        cal_write(REG_C3, c3);
        cal_write(REG_C4, c4);
        cal_write(REG_C5, c5);
        cal_write(REG_C6, c6);
    endtask

    task automatic send_request(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= '{raw_pressure: d1, raw_temperature: d2};
        do @(posedge clk); while (req_stall);
    endtask

    // stop sending and wait until every reading is back
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [RAW_W-1:0] clamp_raw(input longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return '1;
        return v[RAW_W-1:0];
    endfunction

    function automatic longint reference_raw();
        return longint'(board.cal[REG_C5]) * 256;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return RAW_W'($urandom_range(0, 4095));
            default: return RAW_W'($urandom());
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_temperature();
        longint anchor;
        anchor = reference_raw();
        case ($urandom_range(0, 5))
            0:       return RAW_W'($urandom());
            1:       return clamp_raw(anchor + longint'($urandom_range(0, 8000)) - 4000);
            2:       return clamp_raw(anchor - longint'($urandom_range(0, 2500000)));
            3:       return clamp_raw(anchor + longint'($urandom_range(0, 4000000)));
            4:       return clamp_raw(anchor - longint'($urandom_range(0, 16777215)));
            default: return clamp_raw(anchor);
        endcase
    endfunction

    function automatic logic [CAL_W-1:0] pick_cal_word();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return CAL_MAX;
            default: return CAL_W'($urandom());
        endcase
    endfunction

    task automatic send_corners();
        send_request('0, '0);
        send_request('1, '0);
        send_request('0, clamp_raw(reference_raw()));
        send_request('1, clamp_raw(reference_raw()));
        send_request('0, '1);
        send_request('1, '1);
    endtask

    initial
    begin
        int ph;
        int k;
        logic [RAW_W-1:0] d1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // calibration still zero from reset
        send_corners();
        settle();

        load_cal(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
        cal_write(UNMAPPED_IDX, CAL_W'($urandom()));
        send_corners();
        foreach (DT_PROBES[i]) begin
            d1 = (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : RAW_W'($urandom());
            send_request(d1, clamp_raw(reference_raw() + DT_PROBES[i]));
        end
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_cal(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646,
                            16'd26146);
                1: load_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
                2: load_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, '0, CAL_MAX);
                3: load_cal(CAL_W'($urandom()), CAL_W'($urandom()), CAL_W'($urandom()),
                            CAL_W'($urandom()), CAL_W'($urandom()), CAL_W'($urandom()));
                default: load_cal(pick_cal_word(), pick_cal_word(), pick_cal_word(),
                                  pick_cal_word(), pick_cal_word(), pick_cal_word());
            endcase
            send_corners();
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 0 && k == 10)
                    hold_off_pending = 1'b1;
                if (ph == 2 && k == ITEMS_PER_PHASE / 2)
                    settle();
                send_request(pick_raw_pressure(), pick_raw_temperature());
            end
            settle();
        end

        if (board.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
